FILE: hdl/srot_pkg.sv
`timescale 1ns / 1ps

package srot_pkg;

	// Operation codes; codes above SHRD are unused and write nothing
	typedef enum logic [3:0] {
		OP_SHL  = 4'd0,
		OP_SHR  = 4'd1,
		OP_SAR  = 4'd2,
		OP_ROL  = 4'd3,
		OP_ROR  = 4'd4,
		OP_RCL  = 4'd5,
		OP_RCR  = 4'd6,
		OP_SHLD = 4'd7,
		OP_SHRD = 4'd8
	} op_e;

	// Operand size codes
	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;
	localparam logic [1:0] SZ_32 = 2'd2;
	localparam logic [1:0] SZ_64 = 2'd3;

	localparam int XW = 130;	// funnel source: two copies of a 65-bit word
	localparam int AW = 7;		// funnel shift amount, 0..64

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [XW-1:0] x;
		logic [AW-1:0] amt;
		logic [1:0]    size_code;
		logic          force_zero;
		logic          write_dest;
		logic          carry_valid;
		logic          ovf_from_result;
		logic          overflow_valid;
		logic          overflow_pre;
	} srot_item_t;

	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		logic [63:0] m;
		unique case (sz)
			SZ_8:    m = 64'h0000_0000_0000_00FF;
			SZ_16:   m = 64'h0000_0000_0000_FFFF;
			SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [AW-1:0] width_of(input logic [1:0] sz);
		logic [AW-1:0] w;
		unique case (sz)
			SZ_8:    w = 7'd8;
			SZ_16:   w = 7'd16;
			SZ_32:   w = 7'd32;
			default: w = 7'd64;
		endcase
		return w;
	endfunction

	// Bit at the operand width position (bit W of a 65-bit word)
	function automatic logic bit_at_width(input logic [64:0] v, input logic [1:0] sz);
		logic b;
		unique case (sz)
			SZ_8:    b = v[8];
			SZ_16:   b = v[16];
			SZ_32:   b = v[32];
			default: b = v[64];
		endcase
		return b;
	endfunction

	// Top bit of the operand (bit W-1)
	function automatic logic msb_of(input logic [63:0] v, input logic [1:0] sz);
		logic b;
		unique case (sz)
			SZ_8:    b = v[7];
			SZ_16:   b = v[15];
			SZ_32:   b = v[31];
			default: b = v[63];
		endcase
		return b;
	endfunction

	// Move a word up by the operand width
	function automatic logic [XW-1:0] place_w(input logic [XW-1:0] v, input logic [1:0] sz);
		logic [XW-1:0] r;
		unique case (sz)
			SZ_8:    r = v << 8;
			SZ_16:   r = v << 16;
			SZ_32:   r = v << 32;
			default: r = v << 64;
		endcase
		return r;
	endfunction

	// Move a word up by the operand width plus one
	function automatic logic [XW-1:0] place_w1(input logic [XW-1:0] v, input logic [1:0] sz);
		logic [XW-1:0] r;
		unique case (sz)
			SZ_8:    r = v << 9;
			SZ_16:   r = v << 17;
			SZ_32:   r = v << 33;
			default: r = v << 65;
		endcase
		return r;
	endfunction

	// Masked count modulo W+1; only the narrow sizes can wrap
	function automatic logic [5:0] rc_mod(input logic [5:0] c, input logic [1:0] sz);
		logic [5:0] k;
		k = c;
		if (sz == SZ_8) begin
			if (c >= 6'd27)      k = c - 6'd27;
			else if (c >= 6'd18) k = c - 6'd18;
			else if (c >= 6'd9)  k = c - 6'd9;
		end else if (sz == SZ_16) begin
			if (c >= 6'd17) k = c - 6'd17;
		end
		return k;
	endfunction

endpackage

FILE: hdl/srot_front.sv
`timescale 1ns / 1ps

module srot_front import srot_pkg::*; (
	input  logic [3:0]  operation,
	input  logic [1:0]  size_code,
	input  logic [63:0] value,
	input  logic [63:0] fill_value,
	input  logic [7:0]  count,
	input  logic        carry_in,
	output srot_item_t  item
);

	logic [63:0]    m;
	logic [63:0]    a;
	logic [63:0]    src;
	logic [5:0]     c;
	logic [AW-1:0]  c7;
	logic [AW-1:0]  w7;
	logic [AW-1:0]  k7;
	logic [AW-1:0]  kr7;
	logic [5:0]     kr;
	logic           neg;
	logic [63:0]    sx;
	logic [XW-1:0]  a_x;
	logic [XW-1:0]  src_x;
	logic [XW-1:0]  rc_x;
	logic [XW-1:0]  rot_x;
	logic [XW-1:0]  rcv_x;

	// Mask operands and count to the operand size
	always_comb begin
		m     = size_mask(size_code);
		a     = value & m;
		src   = fill_value & m;
		c     = count[5:0] & ((size_code == SZ_64) ? 6'h3F : 6'h1F);
		c7    = {1'b0, c};
		w7    = width_of(size_code);
		k7    = c7 & (w7 - 7'd1);
		kr    = rc_mod(c, size_code);
		kr7   = {1'b0, kr};
		neg   = msb_of(a, size_code);
		sx    = a | (neg ? ~m : 64'd0);
		a_x   = {66'd0, a};
		src_x = {66'd0, src};
		rot_x = a_x | place_w(a_x, size_code);
		rcv_x = a_x | place_w({129'd0, carry_in}, size_code);
		rc_x  = rcv_x | place_w1(rcv_x, size_code);
	end

	// Classify: build the funnel source and right-shift amount for each operation
	always_comb begin
		item                 = '0;
		item.x               = a_x;
		item.size_code       = size_code;
		unique case (operation)
			OP_SHL: begin
				item.write_dest = 1'b1;
				if (c7 >= w7) begin
					item.force_zero = 1'b1;
				end else begin
					item.x   = place_w(a_x, size_code);
					item.amt = w7 - c7;
				end
			end
			OP_SHR: begin
				item.write_dest = 1'b1;
				item.amt        = c7;
			end
			OP_SAR: begin
				item.write_dest = 1'b1;
				item.x          = {{66{neg}}, sx};
				item.amt        = c7;
			end
			OP_ROL: begin
				item.write_dest = 1'b1;
				item.x          = rot_x;
				item.amt        = (w7 - k7) & (w7 - 7'd1);
			end
			OP_ROR: begin
				item.write_dest = 1'b1;
				item.x          = rot_x;
				item.amt        = k7;
			end
			OP_RCL: begin
				if (c != 6'd0 && kr != 6'd0) begin
					item.write_dest  = 1'b1;
					item.carry_valid = 1'b1;
					item.x           = rc_x;
					item.amt         = w7 + 7'd1 - kr7;
					if (c == 6'd1) begin
						item.overflow_valid  = 1'b1;
						item.ovf_from_result = 1'b1;
					end
				end
			end
			OP_RCR: begin
				if (c != 6'd0 && kr != 6'd0) begin
					item.write_dest  = 1'b1;
					item.carry_valid = 1'b1;
					item.x           = rc_x;
					item.amt         = kr7;
					if (c == 6'd1) begin
						item.overflow_valid = 1'b1;
						item.overflow_pre   = neg ^ carry_in;
					end
				end
			end
			OP_SHLD: begin
				if (c != 6'd0) begin
					item.write_dest = 1'b1;
					if (c7 >= w7) begin
						item.force_zero = 1'b1;
					end else begin
						item.x   = place_w(a_x, size_code) | src_x;
						item.amt = w7 - c7;
					end
				end
			end
			OP_SHRD: begin
				if (c != 6'd0) begin
					item.write_dest = 1'b1;
					if (c7 >= w7) begin
						item.force_zero = 1'b1;
					end else begin
						item.x   = a_x | place_w(src_x, size_code);
						item.amt = c7;
					end
				end
			end
			default: begin
				item.x = a_x;
			end
		endcase
	end

endmodule

FILE: hdl/srot_queue.sv
`timescale 1ns / 1ps

module srot_queue import srot_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  srot_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output srot_item_t pop_item
);

	srot_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store a transfer in the slot under the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: hdl/srot_back.sv
`timescale 1ns / 1ps

module srot_back import srot_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  srot_item_t  item,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] result,
	output logic        write_dest,
	output logic        carry_out,
	output logic        carry_valid,
	output logic        overflow_out,
	output logic        overflow_valid
);

	logic [XW-1:0] sh;
	logic [63:0]   r;
	logic          cf;
	logic          top;
	logic          of;
	logic          load;
	logic          valid_q;
	logic [63:0]   result_q;
	logic          write_dest_q;
	logic          carry_out_q;
	logic          carry_valid_q;
	logic          overflow_out_q;
	logic          overflow_valid_q;

	// Funnel shift right, then pick result, carry and overflow
	always_comb begin
		sh  = item.x >> item.amt;
		r   = item.force_zero ? 64'd0 : (sh[63:0] & size_mask(item.size_code));
		cf  = bit_at_width(sh[64:0], item.size_code);
		top = msb_of(r, item.size_code);
		of  = item.ovf_from_result ? (top ^ cf) : item.overflow_pre;
	end

	assign item_ready = !valid_q || res_ready;
	assign load       = item_valid && item_ready;

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q         <= r;
			write_dest_q     <= item.write_dest;
			carry_out_q      <= item.carry_valid & cf;
			carry_valid_q    <= item.carry_valid;
			overflow_out_q   <= item.overflow_valid & of;
			overflow_valid_q <= item.overflow_valid;
		end
	end

	assign res_valid      = valid_q;
	assign result         = result_q;
	assign write_dest     = write_dest_q;
	assign carry_out      = carry_out_q;
	assign carry_valid    = carry_valid_q;
	assign overflow_out   = overflow_out_q;
	assign overflow_valid = overflow_valid_q;

endmodule

FILE: hdl/x86_shift_rotate_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// op        op_valid / op_ready   operation, size_code, value, fill_value, count, carry_in
// res       res_valid / res_ready result, write_dest, carry_out, carry_valid,
//                                 overflow_out, overflow_valid
//
// One operation per cycle sustained while res_ready is high; a transfer is decoded into a
// two-entry queue, then goes through one funnel shifter into the output register.
// The 130-bit funnel shifter in the back is combinational.
// arst_n clears queue occupancy and the output valid; payload registers are not reset.
// A stall on res backs up the queue; op_ready drops only when both queue slots are full.

module x86_shift_rotate_unit import srot_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  logic [3:0]  operation,
	input  logic [1:0]  size_code,
	input  logic [63:0] value,
	input  logic [63:0] fill_value,
	input  logic [7:0]  count,
	input  logic        carry_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] result,
	output logic        write_dest,
	output logic        carry_out,
	output logic        carry_valid,
	output logic        overflow_out,
	output logic        overflow_valid
);

	srot_item_t front_item;
	srot_item_t queue_item;
	logic       queue_valid;
	logic       queue_ready;

	// Decode and classify the incoming operation
	srot_front u_front (
		.operation  (operation),
		.size_code  (size_code),
		.value      (value),
		.fill_value (fill_value),
		.count      (count),
		.carry_in   (carry_in),
		.item       (front_item)
	);

	// Decouple front from back
	srot_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_valid),
		.push_ready (op_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	// Execute and register the result
	srot_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (queue_valid),
		.item_ready     (queue_ready),
		.item           (queue_item),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.result         (result),
		.write_dest     (write_dest),
		.carry_out      (carry_out),
		.carry_valid    (carry_valid),
		.overflow_out   (overflow_out),
		.overflow_valid (overflow_valid)
	);

	a_ovf_needs_carry: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow_valid |-> carry_valid)
		else $error("overflow flag valid without carry flag");

	a_carry_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && carry_valid |-> write_dest)
		else $error("carry flag valid on a skipped write");

	a_carry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !carry_valid |-> !carry_out)
		else $error("carry_out set while not valid");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !overflow_valid |-> !overflow_out)
		else $error("overflow_out set while not valid");

endmodule
